>>> sv/cis_pkg.sv
// Shared types, codes and constants of the copper instruction step block.
// Used by every module in this folder; depends on nothing else.
package cis_pkg;

  localparam int SLOT_CYCLES_DEF      = 1;
  localparam int LINE_START_SLOTS_DEF = 16;

  localparam int CYC_W     = 22;
  localparam int NOW_W     = 20;
  localparam int LEN_W     = 11;
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITERS = (CYC_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W     = DIV_ITERS * DIV_STEP;
  localparam int CNT_W     = $clog2(DIV_ITERS);

  localparam logic [2:0] OC_END     = 3'd0;
  localparam logic [2:0] OC_MOVE    = 3'd1;
  localparam logic [2:0] OC_REFUSED = 3'd2;
  localparam logic [2:0] OC_WAIT    = 3'd3;
  localparam logic [2:0] OC_BLIT    = 3'd4;
  localparam logic [2:0] OC_SKIP    = 3'd5;

  localparam logic [1:0] STEP_REPEAT = 2'd0;
  localparam logic [1:0] STEP_NEXT   = 2'd1;
  localparam logic [1:0] STEP_SKIP   = 2'd2;

  localparam logic [2:0] ADDR_CIL    = 3'd0;
  localparam logic [2:0] ADDR_DANGER = 3'd4;

  typedef struct packed {
    logic [2:0]       outcome;
    logic             we;
    logic [8:0]       addr;
    logic [15:0]      data;
    logic [1:0]       step;
    logic             nvalid;
    logic [8:0]       y;
    logic [CYC_W-1:0] add;
    logic             np;
    logic [NOW_W-1:0] now;
  } job_t;

  function automatic logic [4:0] move_delay(input logic [3:0] code);
    logic [4:0] d;
    begin
      case (code)
        4'd5:    d = 5'd5;
        4'd6:    d = 5'd6;
        4'd11:   d = 5'd8;
        4'd12:   d = 5'd16;
        default: d = 5'd4;
      endcase
      return d;
    end
  endfunction

endpackage

>>> sv/cis_front.sv
// Front end: classifies one instruction and prepares its schedule terms.
// Depends on cis_pkg.
module cis_front #(
  parameter int SLOT_CYCLES      = cis_pkg::SLOT_CYCLES_DEF,
  parameter int LINE_START_SLOTS = cis_pkg::LINE_START_SLOTS_DEF
) (
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [8:0]  raster_line,
  input  logic [7:0]  line_slot,
  input  logic [19:0] frame_cycle,
  input  logic [3:0]  bitplane_depth_code,
  input  logic        blitter_busy,
  input  logic [19:0] blitter_end_cycle,
  input  logic        danger,
  output cis_pkg::job_t job
);

  localparam int W = cis_pkg::CYC_W;
  localparam logic [W-1:0] S4  = W'(4 * SLOT_CYCLES);
  localparam logic [W-1:0] SC  = W'(SLOT_CYCLES);
  localparam logic [W-1:0] LS4 = W'(LINE_START_SLOTS + 4);

  logic [15:0] fwm, swm, inv;
  logic [7:0]  wv, my, lo, hslot, x_rw, hinv, x_eq;
  logic [8:0]  a;
  logic        late, permit;
  logic [W-1:0] now4;

  always_comb begin
    fwm   = {first_word[15:1], 1'b0};
    swm   = second_word | 16'h8000;
    inv   = ~swm;
    wv    = fwm[15:8];
    my    = raster_line[7:0] & swm[15:8];
    lo    = (raster_line[7:0] & inv[15:8]) | wv;
    hslot = line_slot & swm[7:0];
    x_rw  = fwm[7:0] | (line_slot & inv[7:0] & 8'hFE);
    hinv  = inv[7:0] & 8'hFE;
    x_eq  = fwm[7:0] | ((hinv < line_slot) ? (hinv & line_slot) : 8'h00);
    late  = (raster_line != 9'd255) || (wv > 8'h40);
    a     = {first_word[8:1], 1'b0};
    permit = (a >= 9'h080) || ((a >= 9'h040) && danger);
    now4  = W'(frame_cycle) + S4;

    job = '0;
    job.step = cis_pkg::STEP_NEXT;
    job.now  = frame_cycle;

    if (first_word == 16'hFFFF && second_word == 16'hFFFE) begin
      job.outcome = cis_pkg::OC_END;
    end else if (!first_word[0]) begin
      if (permit) begin
        job.outcome = cis_pkg::OC_MOVE;
        job.we      = 1'b1;
        job.addr    = a;
        job.data    = second_word;
        job.nvalid  = 1'b1;
        job.add     = W'(frame_cycle) + W'(bitplane_depth_code == 4'd0 ?
                      cis_pkg::move_delay(4'd0) : cis_pkg::move_delay(bitplane_depth_code))
                      * SC;
      end else begin
        job.outcome = cis_pkg::OC_REFUSED;
      end
    end else if (!second_word[15] && blitter_busy) begin
      job.outcome = cis_pkg::OC_BLIT;
      job.step    = cis_pkg::STEP_REPEAT;
      job.nvalid  = 1'b1;
      job.add     = W'(blitter_end_cycle) + S4;
      job.np      = 1'b1;
    end else if (!second_word[0]) begin
      job.outcome = cis_pkg::OC_WAIT;
      job.nvalid  = 1'b1;
      if (my > wv) begin
        if (late) begin
          job.add = now4;
        end else begin
          job.y   = {1'b1, lo};
          job.add = (W'(x_rw) + W'(4)) * SC;
          job.np  = 1'b1;
        end
      end else if (my < wv) begin
        job.y   = {raster_line[8], lo};
        job.add = (W'(fwm[7:0]) + LS4) * SC;
        job.np  = 1'b1;
      end else if (hslot < fwm[7:0]) begin
        job.y   = {raster_line[8], lo};
        job.add = (W'(x_eq) + LS4) * SC;
        job.np  = 1'b1;
      end else if (late) begin
        job.add = now4;
      end else begin
        job.y   = {1'b1, lo};
        job.add = (W'(x_rw) + W'(4)) * SC;
        job.np  = 1'b1;
      end
    end else begin
      job.outcome = cis_pkg::OC_SKIP;
      job.nvalid  = 1'b1;
      job.add     = now4;
      if (my > wv || (my == wv && hslot >= fwm[7:0])) begin
        job.step = cis_pkg::STEP_SKIP;
      end
    end
  end

endmodule

>>> sv/cis_queue.sv
// Two-entry queue of decoded instructions between the front and back end.
// Depends on cis_pkg.
module cis_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cis_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output cis_pkg::job_t rdata
);

  cis_pkg::job_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/cis_back.sv
// Back end: multiplies out the line base, applies the not-past rule, finds the
// slot in the line with an iterative remainder unit, and holds the result.
// Depends on cis_pkg.
module cis_back #(
  parameter int SLOT_CYCLES = cis_pkg::SLOT_CYCLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [10:0]   len,
  input  logic          q_valid,
  input  cis_pkg::job_t job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    outcome,
  output logic          write_enable,
  output logic [8:0]    reg_address,
  output logic [15:0]   reg_data,
  output logic [1:0]    pc_step,
  output logic          next_valid,
  output logic [19:0]   next_cycle
);

  localparam int W  = cis_pkg::CYC_W;
  localparam int DW = cis_pkg::DVD_W;
  localparam logic [W-1:0] S4 = W'(4 * SLOT_CYCLES);
  localparam logic [W-1:0] S2 = W'(2 * SLOT_CYCLES);
  localparam logic [10:0] E2_LO = 11'(226 * SLOT_CYCLES);
  localparam logic [10:0] E2_HI = 11'(227 * SLOT_CYCLES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              state;
  cis_pkg::job_t           jr;
  logic [19:0]             prod;
  logic [W-1:0]            cyc;
  logic [DW-1:0]           dvd, dvd_next;
  logic [10:0]             rem, rem_next;
  logic [cis_pkg::CNT_W-1:0] cnt;
  logic [W-1:0]            sum, now4, cyc_next, ncyc;
  logic [11:0]             t;
  logic                    hit, load;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign load  = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    sum      = W'(prod) + jr.add;
    now4     = W'(jr.now) + S4;
    cyc_next = (jr.np && sum <= W'(jr.now)) ? now4 : sum;
    rem_next = rem;
    dvd_next = dvd;
    t        = '0;
    for (int i = 0; i < cis_pkg::DIV_STEP; i++) begin
      t        = {rem_next, dvd_next[DW-1]};
      dvd_next = {dvd_next[DW-2:0], 1'b0};
      if (t >= {1'b0, len}) begin
        t = t - {1'b0, len};
      end
      rem_next = t[10:0];
    end
    hit  = (rem >= E2_LO) && (rem <= E2_HI);
    ncyc = cyc + (hit ? S2 : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) state <= S_ADD;
        S_ADD:  state <= S_DIV;
        S_DIV:  if (cnt == cis_pkg::CNT_W'(cis_pkg::DIV_ITERS - 1)) state <= S_FIN;
        S_FIN:  if (load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      jr   <= job;
      prod <= 20'(job.y) * 20'(len);
    end
    if (state == S_ADD) begin
      cyc <= cyc_next;
      dvd <= DW'(cyc_next);
      rem <= '0;
      cnt <= '0;
    end
    if (state == S_DIV) begin
      dvd <= dvd_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
    if (load) begin
      outcome      <= jr.outcome;
      write_enable <= jr.we;
      reg_address  <= jr.addr;
      reg_data     <= jr.data;
      pc_step      <= jr.step;
      next_valid   <= jr.nvalid;
      next_cycle   <= jr.nvalid ? ncyc[19:0] : 20'd0;
    end
  end

  a_halt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !next_valid |-> next_cycle == 20'd0)
    else $error("halted transaction carries a next cycle");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < cis_pkg::CNT_W'(cis_pkg::DIV_ITERS))
    else $error("remainder unit ran past its iteration count");

  a_write_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> outcome == cis_pkg::OC_MOVE)
    else $error("register write issued by a non-move transaction");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_ADD)
    else $error("popped job did not enter the add stage");

endmodule

>>> sv/copper_instruction_step.sv
// Top level of the copper instruction step block: configuration registers,
// front decoder, job queue and back end. Depends on cis_pkg and cis_* modules.
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, 8 fields     | item into the block
//   out     | out_valid, out_ready, 7 fields   | result out of the block
//   cfg     | psel/penable/pwrite/paddr/pwdata | register writes and reads
//
// A transaction passes through the back end as one multiply, one add and
// compare, the 4-bit-per-cycle remainder unit and one output load; the back
// end takes the next transaction from the queue only after that load.
// Input is taken while the two-entry queue has room; a held output stalls the
// back end. Reset is synchronous, clears control state, sets config defaults.
module copper_instruction_step #(
  parameter int SLOT_CYCLES      = cis_pkg::SLOT_CYCLES_DEF,
  parameter int LINE_START_SLOTS = cis_pkg::LINE_START_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [8:0]  raster_line,
  input  logic [7:0]  line_slot,
  input  logic [19:0] frame_cycle,
  input  logic [3:0]  bitplane_depth_code,
  input  logic        blitter_busy,
  input  logic [19:0] blitter_end_cycle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic        write_enable,
  output logic [8:0]  reg_address,
  output logic [15:0] reg_data,
  output logic [1:0]  pc_step,
  output logic        next_valid,
  output logic [19:0] next_cycle
);

  logic [10:0]   cycles_in_line;
  logic          danger_enable;
  logic [10:0]   len;
  cis_pkg::job_t job_in, job_out;
  logic          full, not_empty, pop;

  assign pready = 1'b1;
  assign len    = (cycles_in_line == 11'd0) ? 11'd1 : cycles_in_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_in_line <= 11'd227;
      danger_enable  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        cis_pkg::ADDR_CIL:    cycles_in_line <= pwdata[10:0];
        cis_pkg::ADDR_DANGER: danger_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      cis_pkg::ADDR_CIL:    prdata = {21'd0, cycles_in_line};
      cis_pkg::ADDR_DANGER: prdata = {31'd0, danger_enable};
      default:              prdata = 32'd0;
    endcase
  end

  assign in_ready = !full;

  cis_front #(
    .SLOT_CYCLES      (SLOT_CYCLES),
    .LINE_START_SLOTS (LINE_START_SLOTS)
  ) u_front (
    .first_word          (first_word),
    .second_word         (second_word),
    .raster_line         (raster_line),
    .line_slot           (line_slot),
    .frame_cycle         (frame_cycle),
    .bitplane_depth_code (bitplane_depth_code),
    .blitter_busy        (blitter_busy),
    .blitter_end_cycle   (blitter_end_cycle),
    .danger              (danger_enable),
    .job                 (job_in)
  );

  cis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !full),
    .wdata     (job_in),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rdata     (job_out)
  );

  cis_back #(
    .SLOT_CYCLES (SLOT_CYCLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .len          (len),
    .q_valid      (not_empty),
    .job          (job_out),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .write_enable (write_enable),
    .reg_address  (reg_address),
    .reg_data     (reg_data),
    .pc_step      (pc_step),
    .next_valid   (next_valid),
    .next_cycle   (next_cycle)
  );

endmodule
